// ----- rtl/core/brb_pkg.sv -----
// Shared constants, command codes and state type for the byte ring buffer.
package brb_pkg;

   localparam int DEPTH    = 4096;
   localparam int PTR_W    = $clog2(DEPTH);
   localparam int MAX_RUN  = 64;
   localparam int MARGIN   = 256;
   localparam int FIELD_W  = 12;
   localparam int LEN_W    = 13;
   localparam int CMD_W    = 3;
   localparam int BYTE_W   = 8;
   localparam int ROOM_EMPTY = DEPTH - MARGIN;

   localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH    = 3'd0,
      CMD_READ    = 3'd1,
      CMD_PEEK    = 3'd2,
      CMD_ADVANCE = 3'd3,
      CMD_SCAN    = 3'd4,
      CMD_SKIP    = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_SCAN,
      ST_SKIP_CR,
      ST_SKIP_LF
   } state_type;

endpackage

// ----- rtl/core/brb_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module brb_ram #(
   parameter int DATA_W = 8,
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/brb_status.sv -----
// Backlog and room computation from a pair of ring pointers.
module brb_status (
   input  logic [brb_pkg::PTR_W-1:0]   rd_ptr,
   input  logic [brb_pkg::PTR_W-1:0]   wr_ptr,
   output logic [brb_pkg::PTR_W-1:0]   backlog,
   output logic [brb_pkg::FIELD_W-1:0] room
);

   logic [brb_pkg::PTR_W-1:0] free_bytes;

   // Pointer differences wrap naturally because the depth is a power of two.
   assign backlog    = wr_ptr - rd_ptr;
   assign free_bytes = rd_ptr - wr_ptr;

   always_comb begin
      if (rd_ptr == wr_ptr) begin
         room = brb_pkg::FIELD_W'(brb_pkg::ROOM_EMPTY);
      end else if (32'(free_bytes) < 32'(brb_pkg::MARGIN)) begin
         room = '0;
      end else begin
         room = brb_pkg::FIELD_W'(32'(free_bytes) - 32'(brb_pkg::MARGIN));
      end
   end

endmodule

// ----- rtl/core/byte_ring_buffer_with_line_scan_unit.sv -----
// Top level: command sequencer around the byte store RAM and the ring pointers.
//
// A push is taken in the cycle start is seen with busy low and its status result appears on the
// next cycle; pushes may follow one another every cycle. Advance and unknown commands also
// never raise busy. A read or peek of n bytes (n is the request clamped to 64 and to the
// backlog) delivers its bytes on consecutive cycles, each passing the store's registered read
// port and the result register. A line scan walks the store one byte per cycle; skip terminator
// reads the byte at the read pointer and drops it if it is a CR, then likewise an LF. Reads and
// scans are paced by the single read port of the byte store. Results cannot be held off by the
// receiver: each one stands on the rsp_ ports for exactly one cycle, marked by rsp_strobe.
// An empty read, peek or scan returns a single status result at once.
module byte_ring_buffer_with_line_scan_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [brb_pkg::CMD_W-1:0]    req_cmd,
   input  logic [brb_pkg::BYTE_W-1:0]   req_data_in,
   input  logic [brb_pkg::LEN_W-1:0]    req_length,
   output logic                         rsp_strobe,
   output logic [brb_pkg::BYTE_W-1:0]   rsp_data_out,
   output logic                         rsp_data_valid,
   output logic                         rsp_last,
   output logic                         rsp_line_found,
   output logic [brb_pkg::FIELD_W-1:0]  rsp_line_length,
   output logic [brb_pkg::FIELD_W-1:0]  rsp_backlog,
   output logic [brb_pkg::FIELD_W-1:0]  rsp_room
);

   localparam int PW = brb_pkg::PTR_W;

   brb_pkg::state_type state_ff, state_in;

   logic [PW-1:0] rp_ff, rp_in, wp_ff, wp_in;
   logic [PW-1:0] addr_ff, addr_in;
   logic [PW-1:0] total_ff, total_in;
   logic [PW-1:0] issued_ff, issued_in;
   logic [PW-1:0] recv_ff, recv_in;
   logic          pend_ff, pend_in;
   logic          prev_cr_ff, prev_cr_in;

   logic                        strobe_ff;
   logic [brb_pkg::BYTE_W-1:0]  data_ff;
   logic                        dvalid_ff, last_ff, found_ff;
   logic [brb_pkg::FIELD_W-1:0] llen_ff, backlog_ff, room_ff;

   logic                        emit;
   logic [brb_pkg::BYTE_W-1:0]  e_data;
   logic                        e_dvalid, e_last, e_found;
   logic [brb_pkg::FIELD_W-1:0] e_llen;

   logic                       wr_en, rd_en;
   logic [PW-1:0]              wr_addr, rd_addr;
   logic [brb_pkg::BYTE_W-1:0] wr_data, rd_data;

   logic [PW-1:0]               cur_backlog, next_backlog;
   logic [brb_pkg::FIELD_W-1:0] next_room;

   logic          accept;
   logic [PW-1:0] run_cap, run_len, adv_len;
   logic          run_empty, ring_empty, recv_done;

   brb_ram #(
      .DATA_W (brb_pkg::BYTE_W),
      .ADDR_W (PW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Results report the pointers as they stand once the item has acted.
   brb_status u_next_status (
      .rd_ptr  (rp_in),
      .wr_ptr  (wp_in),
      .backlog (next_backlog),
      .room    (next_room)
   );

   assign cur_backlog = wp_ff - rp_ff;

   assign busy       = (state_ff != brb_pkg::ST_IDLE);
   assign accept     = start && !busy;
   assign ring_empty = (rp_ff == wp_ff);
   assign recv_done  = ((recv_ff + 1'b1) == total_ff);

   assign run_cap   = (32'(req_length) > 32'(brb_pkg::MAX_RUN)) ?
                      PW'(brb_pkg::MAX_RUN) : PW'(req_length);
   assign run_len   = (run_cap > cur_backlog) ? cur_backlog : run_cap;
   assign run_empty = (run_len == '0);
   assign adv_len   = (32'(req_length) > 32'(cur_backlog)) ? cur_backlog : PW'(req_length);

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         brb_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  brb_pkg::CMD_READ, brb_pkg::CMD_PEEK: begin
                     if (!run_empty) begin
                        state_in = brb_pkg::ST_RUN;
                     end
                  end
                  brb_pkg::CMD_SCAN: begin
                     if (cur_backlog != '0) begin
                        state_in = brb_pkg::ST_SCAN;
                     end
                  end
                  brb_pkg::CMD_SKIP: state_in = brb_pkg::ST_SKIP_CR;
                  default:           state_in = brb_pkg::ST_IDLE;
               endcase
            end
         end
         brb_pkg::ST_RUN: begin
            if (pend_ff && recv_done) begin
               state_in = brb_pkg::ST_IDLE;
            end
         end
         brb_pkg::ST_SCAN: begin
            if (pend_ff && (rd_data == brb_pkg::CH_LF || recv_done)) begin
               state_in = brb_pkg::ST_IDLE;
            end
         end
         brb_pkg::ST_SKIP_CR: begin
            if (pend_ff) begin
               state_in = brb_pkg::ST_SKIP_LF;
            end
         end
         brb_pkg::ST_SKIP_LF: begin
            if (pend_ff) begin
               state_in = brb_pkg::ST_IDLE;
            end
         end
         default: state_in = brb_pkg::ST_IDLE;
      endcase
   end

   // Datapath, memory access and result logic.
   always_comb begin
      rp_in      = rp_ff;
      wp_in      = wp_ff;
      addr_in    = addr_ff;
      total_in   = total_ff;
      issued_in  = issued_ff;
      recv_in    = recv_ff;
      pend_in    = 1'b0;
      prev_cr_in = prev_cr_ff;
      wr_en      = 1'b0;
      wr_addr    = wp_ff;
      wr_data    = req_data_in;
      rd_en      = 1'b0;
      rd_addr    = addr_ff;
      emit       = 1'b0;
      e_data     = '0;
      e_dvalid   = 1'b0;
      e_last     = 1'b1;
      e_found    = 1'b0;
      e_llen     = '0;

      case (state_ff)
         brb_pkg::ST_IDLE: begin
            if (accept) begin
               addr_in    = rp_ff;
               issued_in  = '0;
               recv_in    = '0;
               prev_cr_in = 1'b0;
               case (req_cmd)
                  brb_pkg::CMD_PUSH: begin
                     wr_en = 1'b1;
                     wp_in = wp_ff + 1'b1;
                     emit  = 1'b1;
                  end
                  brb_pkg::CMD_READ, brb_pkg::CMD_PEEK: begin
                     total_in = run_len;
                     if (req_cmd == brb_pkg::CMD_READ) begin
                        rp_in = rp_ff + run_len;
                     end
                     emit = run_empty;
                  end
                  brb_pkg::CMD_ADVANCE: begin
                     rp_in = rp_ff + adv_len;
                     emit  = 1'b1;
                  end
                  brb_pkg::CMD_SCAN: begin
                     total_in = cur_backlog;
                     emit     = (cur_backlog == '0);
                  end
                  brb_pkg::CMD_SKIP: begin
                     emit = 1'b0;
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end
         brb_pkg::ST_RUN, brb_pkg::ST_SCAN: begin
            if (issued_ff != total_ff) begin
               rd_en     = 1'b1;
               addr_in   = addr_ff + 1'b1;
               issued_in = issued_ff + 1'b1;
               pend_in   = 1'b1;
            end
            if (pend_ff) begin
               recv_in = recv_ff + 1'b1;
               if (state_ff == brb_pkg::ST_RUN) begin
                  emit     = 1'b1;
                  e_data   = rd_data;
                  e_dvalid = 1'b1;
                  e_last   = recv_done;
               end else if (rd_data == brb_pkg::CH_LF) begin
                  // A CR just ahead of the LF is not part of the line.
                  emit    = 1'b1;
                  e_found = 1'b1;
                  e_llen  = brb_pkg::FIELD_W'(recv_ff -
                            PW'((recv_ff != '0) && prev_cr_ff));
               end else begin
                  prev_cr_in = (rd_data == brb_pkg::CH_CR);
                  if (recv_done) begin
                     emit   = 1'b1;
                     e_llen = brb_pkg::FIELD_W'(total_ff);
                  end
               end
            end
         end
         brb_pkg::ST_SKIP_CR, brb_pkg::ST_SKIP_LF: begin
            if (!pend_ff) begin
               rd_en   = 1'b1;
               rd_addr = rp_ff;
               pend_in = 1'b1;
            end else begin
               if (!ring_empty &&
                   rd_data == ((state_ff == brb_pkg::ST_SKIP_CR) ?
                               brb_pkg::CH_CR : brb_pkg::CH_LF)) begin
                  rp_in = rp_ff + 1'b1;
               end
               emit = (state_ff == brb_pkg::ST_SKIP_LF);
            end
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= brb_pkg::ST_IDLE;
         rp_ff     <= '0;
         wp_ff     <= '0;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rp_ff     <= rp_in;
         wp_ff     <= wp_in;
         pend_ff   <= pend_in;
         strobe_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      total_ff   <= total_in;
      issued_ff  <= issued_in;
      recv_ff    <= recv_in;
      prev_cr_ff <= prev_cr_in;
      if (emit) begin
         data_ff    <= e_data;
         dvalid_ff  <= e_dvalid;
         last_ff    <= e_last;
         found_ff   <= e_found;
         llen_ff    <= e_llen;
         backlog_ff <= brb_pkg::FIELD_W'(next_backlog);
         room_ff    <= next_room;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_data_out    = data_ff;
   assign rsp_data_valid  = dvalid_ff;
   assign rsp_last        = last_ff;
   assign rsp_line_found  = found_ff;
   assign rsp_line_length = llen_ff;
   assign rsp_backlog     = backlog_ff;
   assign rsp_room        = room_ff;

endmodule

// ----- rtl/core/brb_checker.sv -----
// Port-level checker for the byte ring buffer, bound to the top level.
module brb_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic [brb_pkg::CMD_W-1:0]    req_cmd,
   input logic                         rsp_strobe,
   input logic                         rsp_data_valid,
   input logic                         rsp_last,
   input logic                         rsp_line_found,
   input logic [brb_pkg::FIELD_W-1:0]  rsp_backlog,
   input logic [brb_pkg::FIELD_W-1:0]  rsp_room
);

   logic [brb_pkg::FIELD_W:0] free_bytes;
   assign free_bytes = (brb_pkg::FIELD_W+1)'(brb_pkg::DEPTH) -
                       (brb_pkg::FIELD_W+1)'(rsp_backlog);

   // A push transfer is answered by a single status result on the next cycle.
   a_push_status: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_cmd == brb_pkg::CMD_PUSH |=> rsp_strobe && rsp_last)
      else $error("push did not produce a status result");

   // The bytes of a run are delivered on consecutive cycles.
   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe && rsp_data_valid)
      else $error("gap inside a read run");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data_valid |-> rsp_last)
      else $error("status result without last mark");

   a_found_status: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_line_found |-> !rsp_data_valid)
      else $error("line found on a data result");

   // Room follows from the backlog: free space less the margin, floored at zero.
   a_room_backlog: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |->
         (rsp_backlog == '0 &&
          32'(rsp_room) == 32'(brb_pkg::ROOM_EMPTY)) ||
         (rsp_backlog != '0 && 32'(free_bytes) < 32'(brb_pkg::MARGIN) &&
          rsp_room == '0) ||
         (rsp_backlog != '0 && 32'(free_bytes) >= 32'(brb_pkg::MARGIN) &&
          32'(rsp_room) == 32'(free_bytes) - 32'(brb_pkg::MARGIN)))
      else $error("room does not match backlog");

endmodule

bind byte_ring_buffer_with_line_scan_unit brb_checker u_brb_checker (.*);
